// ===== sv/tdslp_pkg.sv =====
// Package for the tagged decimal sensor line parser.
// Holds the parse mode type, the ASCII codes the parser matches and the output value type; no dependencies.
package tdslp_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_LIGHT = 3'd1,
    MODE_SOIL  = 3'd2,
    MODE_HUM   = 3'd3,
    MODE_TEMP  = 3'd4
  } mode_t;

  localparam logic [7:0] CH_L       = 8'h4C;
  localparam logic [7:0] CH_S       = 8'h53;
  localparam logic [7:0] CH_H       = 8'h48;
  localparam logic [7:0] CH_T       = 8'h54;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  localparam int unsigned OUT_WIDTH = 16;

  typedef logic [OUT_WIDTH-1:0] out_val_t;

endpackage

// ===== sv/tagged_decimal_sensor_line_parser.sv =====
// Top level of the tagged decimal sensor line parser.
// Uses tdslp_pkg and tdslp_fold.
//
// Usage:
//   Input channel (in_valid, in_stall, in_rx_byte) takes one ASCII byte per
//   word. Tags L, S, H, T open a field and clear its value; digits fold in as
//   value*10+digit with saturation; a space closes the field. A newline
//   outside a field, after at least one tag since the last report, sends one
//   result word on the output channel (out_valid, out_stall, four 16-bit
//   values).
//   Throughput: one byte per cycle while in_stall is low. A result word
//   reaches the output once its newline is parsed out of the input
//   register into the result register.
//   Reset (rst_n low, synchronous) empties both registers, leaves all
//   fields closed, clears the values and the tag seen flag.
//   While out_stall holds a waiting result, the result register keeps its
//   word; the input register takes one more byte only if it is empty, then
//   in_stall rises until the result is taken.
module tagged_decimal_sensor_line_parser #(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_rx_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output tdslp_pkg::out_val_t out_soil_moisture,
  output tdslp_pkg::out_val_t out_light_level,
  output tdslp_pkg::out_val_t out_temperature,
  output tdslp_pkg::out_val_t out_humidity
);
  import tdslp_pkg::*;

  logic [7:0]             byte_r;
  logic                   byte_vld_r;
  mode_t                  mode_r, mode_nxt;
  logic [VALUE_WIDTH-1:0] light_r, light_nxt;
  logic [VALUE_WIDTH-1:0] soil_r, soil_nxt;
  logic [VALUE_WIDTH-1:0] hum_r, hum_nxt;
  logic [VALUE_WIDTH-1:0] temp_r, temp_nxt;
  logic                   seen_r, seen_nxt;
  logic                   out_vld_r;
  out_val_t               soil_out_r, light_out_r, temp_out_r, hum_out_r;

  logic                   can_proc;
  logic                   proc;
  logic                   emit;
  logic [VALUE_WIDTH-1:0] acc_sel;
  logic [VALUE_WIDTH-1:0] acc_fold;

  assign can_proc = !out_vld_r || !out_stall;
  assign in_stall = byte_vld_r && !can_proc;
  assign proc     = byte_vld_r && can_proc;

  always_comb begin
    case (mode_r)
      MODE_LIGHT: acc_sel = light_r;
      MODE_SOIL:  acc_sel = soil_r;
      MODE_HUM:   acc_sel = hum_r;
      MODE_TEMP:  acc_sel = temp_r;
      default:    acc_sel = '0;
    endcase
  end

  tdslp_fold #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_fold (
    .acc     (acc_sel),
    .rx_byte (byte_r),
    .acc_out (acc_fold)
  );

  always_comb begin
    mode_nxt  = mode_r;
    light_nxt = light_r;
    soil_nxt  = soil_r;
    hum_nxt   = hum_r;
    temp_nxt  = temp_r;
    seen_nxt  = seen_r;
    emit      = 1'b0;
    if (proc) begin
      unique case (mode_r) inside
        MODE_LIGHT, MODE_SOIL, MODE_HUM, MODE_TEMP: begin
          if (byte_r == CH_SPACE) begin
            mode_nxt = MODE_IDLE;
          end else begin
            case (mode_r)
              MODE_LIGHT: light_nxt = acc_fold;
              MODE_SOIL:  soil_nxt  = acc_fold;
              MODE_HUM:   hum_nxt   = acc_fold;
              default:    temp_nxt  = acc_fold;
            endcase
          end
        end
        default: begin
          mode_nxt = MODE_IDLE;
          unique case (byte_r)
            CH_L: begin
              light_nxt = '0;
              mode_nxt  = MODE_LIGHT;
              seen_nxt  = 1'b1;
            end
            CH_S: begin
              soil_nxt = '0;
              mode_nxt = MODE_SOIL;
              seen_nxt = 1'b1;
            end
            CH_H: begin
              hum_nxt  = '0;
              mode_nxt = MODE_HUM;
              seen_nxt = 1'b1;
            end
            CH_T: begin
              temp_nxt = '0;
              mode_nxt = MODE_TEMP;
              seen_nxt = 1'b1;
            end
            CH_NEWLINE: begin
              if (seen_r) begin
                seen_nxt = 1'b0;
                emit     = 1'b1;
              end
            end
            default: ;
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r <= 1'b0;
      mode_r     <= MODE_IDLE;
      light_r    <= '0;
      soil_r     <= '0;
      hum_r      <= '0;
      temp_r     <= '0;
      seen_r     <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (!in_stall) begin
        byte_vld_r <= in_valid;
      end
      mode_r  <= mode_nxt;
      light_r <= light_nxt;
      soil_r  <= soil_nxt;
      hum_r   <= hum_nxt;
      temp_r  <= temp_nxt;
      seen_r  <= seen_nxt;
      if (can_proc) begin
        out_vld_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      byte_r <= in_rx_byte;
    end
    if (emit) begin
      soil_out_r  <= OUT_WIDTH'(soil_r);
      light_out_r <= OUT_WIDTH'(light_r);
      temp_out_r  <= OUT_WIDTH'(temp_r);
      hum_out_r   <= OUT_WIDTH'(hum_r);
    end
  end

  assign out_valid         = out_vld_r;
  assign out_soil_moisture = soil_out_r;
  assign out_light_level   = light_out_r;
  assign out_temperature   = temp_out_r;
  assign out_humidity      = hum_out_r;

endmodule

// ===== sv/tdslp_fold.sv =====
// Saturating decimal fold: acc*10 + digit, clamped to the accumulator maximum.
// Non-digit bytes count as zero. Uses tdslp_pkg.
module tdslp_fold #(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic [VALUE_WIDTH-1:0] acc,
  input  logic [7:0]             rx_byte,
  output logic [VALUE_WIDTH-1:0] acc_out
);
  import tdslp_pkg::*;

  localparam int unsigned WIDE = VALUE_WIDTH + 4;

  logic [3:0]      digit;
  logic [WIDE-1:0] acc_w;
  logic [WIDE-1:0] sum;

  always_comb begin
    if (rx_byte >= CH_ZERO && rx_byte <= CH_NINE) begin
      digit = 4'(rx_byte - CH_ZERO);
    end else begin
      digit = 4'd0;
    end
    acc_w = WIDE'(acc);
    sum   = (acc_w << 3) + (acc_w << 1) + WIDE'(digit);
    if (sum[WIDE-1:VALUE_WIDTH] != '0) begin
      acc_out = '1;
    end else begin
      acc_out = sum[VALUE_WIDTH-1:0];
    end
  end

endmodule
